// File: rtl/apu_pkg.sv
`timescale 1ns / 1ps

package apu_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_CHANNELS = 4;

    localparam int PIX_W   = 8;
    localparam int NUM_CH  = 4;
    localparam int WORD_W  = PIX_W * NUM_CH;
    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int IMG_W_W = 12;
    localparam int IMG_H_W = 16;
    localparam int BPP_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W   = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_BYTES_PER_PIXEL = 2'd2,
        CFG_NONE            = 2'd3
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_byte;

    typedef struct packed {
        logic              has_left;
        logic              has_up;
        logic [NUM_CH-1:0] ch_en;
    } t_pred_ctl;

endpackage

// File: rtl/average_predictor_unfilter.sv
`timescale 1ns / 1ps
// Pipeline: an input stage, then a result register that drives o_valid.
// Throughput: one pixel per cycle unless the output stalls. The line store is read
//   on accept and written on move; a same-column write in the read cycle is forwarded.
// Reset (synchronous, active low): clears valids, counters and the left pixel, and sets
//   width 1, height 1, 4 bytes per pixel. The line store is not cleared.

module average_predictor_unfilter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [apu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [apu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_diff_ch0,
    input  logic [7:0]                        i_diff_ch1,
    input  logic [7:0]                        i_diff_ch2,
    input  logic [7:0]                        i_diff_ch3,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_pix_ch0,
    output logic [7:0]                        o_pix_ch1,
    output logic [7:0]                        o_pix_ch2,
    output logic [7:0]                        o_pix_ch3,
    output logic                              o_end_of_image
);

    logic [apu_pkg::IMG_W_W-1:0] r_img_w;
    logic [apu_pkg::IMG_H_W-1:0] r_img_h;
    logic [apu_pkg::BPP_W-1:0]   r_bpp;

    logic [apu_pkg::COL_W-1:0]   r_col;
    logic [apu_pkg::IMG_H_W-1:0] r_row;
    logic [apu_pkg::WORD_W-1:0]  r_left;

    logic                        r_s1_valid;
    apu_pkg::t_pred_ctl          r_s1_ctl;
    logic [apu_pkg::WORD_W-1:0]  r_s1_diff;
    logic [apu_pkg::COL_W-1:0]   r_s1_idx;
    logic                        r_s1_eoi;
    logic [apu_pkg::WORD_W-1:0]  r_up_rd;
    logic [apu_pkg::WORD_W-1:0]  r_up_byp;
    logic                        r_use_byp;

    logic                        r_out_valid;
    logic [apu_pkg::WORD_W-1:0]  r_out_pix;
    logic                        r_out_eoi;

    logic [apu_pkg::WORD_W-1:0]  r_mem [apu_pkg::MAX_WIDTH];

    logic                        accept;
    logic                        move;
    logic [apu_pkg::CMP_W-1:0]   eff_w;
    logic [apu_pkg::IMG_H_W:0]   eff_h;
    logic [apu_pkg::BPP_W-1:0]   eff_ch;
    logic                        last_col;
    logic                        last_row;
    logic [apu_pkg::COL_W-1:0]   n_col;
    logic [apu_pkg::IMG_H_W-1:0] n_row;
    apu_pkg::t_pred_ctl          n_ctl;
    logic [apu_pkg::WORD_W-1:0]  up;
    logic [apu_pkg::WORD_W-1:0]  pix;

    assign move    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || move;
    assign accept  = i_valid && o_ready;

    always_comb begin
        eff_w = apu_pkg::CMP_W'(r_img_w);
        if (r_img_w == '0) begin
            eff_w = apu_pkg::CMP_W'(1);
        end else if (eff_w > apu_pkg::CMP_W'(apu_pkg::MAX_WIDTH)) begin
            eff_w = apu_pkg::CMP_W'(apu_pkg::MAX_WIDTH);
        end
        eff_h = (r_img_h == '0) ? (apu_pkg::IMG_H_W+1)'(1) : {1'b0, r_img_h};
        eff_ch = r_bpp;
        if (r_bpp == '0) begin
            eff_ch = apu_pkg::BPP_W'(1);
        end else if (r_bpp > apu_pkg::BPP_W'(apu_pkg::MAX_CHANNELS)) begin
            eff_ch = apu_pkg::BPP_W'(apu_pkg::MAX_CHANNELS);
        end
        last_col = (apu_pkg::CMP_W'(r_col) + apu_pkg::CMP_W'(1)) >= eff_w;
        last_row = ({1'b0, r_row} + (apu_pkg::IMG_H_W+1)'(1)) >= eff_h;
        n_ctl.has_left = (r_col != '0);
        n_ctl.has_up   = (r_row != '0);
        for (int c = 0; c < apu_pkg::NUM_CH; c++) begin
            n_ctl.ch_en[c] = (apu_pkg::BPP_W'(c) < eff_ch);
        end
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    assign up = r_use_byp ? r_up_byp : r_up_rd;

    apu_predict u_predict (
        .i_ctl  (r_s1_ctl),
        .i_diff (r_s1_diff),
        .i_left (r_left),
        .i_up   (up),
        .o_pix  (pix)
    );

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_mem[r_s1_idx] <= pix;
        end
        if (accept) begin
            r_up_rd <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl  <= n_ctl;
            r_s1_diff <= {i_diff_ch3, i_diff_ch2, i_diff_ch1, i_diff_ch0};
            r_s1_idx  <= r_col;
            r_s1_eoi  <= last_col && last_row;
            r_up_byp  <= pix;
            r_use_byp <= move && (r_s1_idx == r_col);
        end
        if (move) begin
            r_out_pix <= pix;
            r_out_eoi <= r_s1_eoi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w     <= apu_pkg::IMG_W_W'(1);
            r_img_h     <= apu_pkg::IMG_H_W'(1);
            r_bpp       <= apu_pkg::BPP_W'(4);
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (apu_pkg::t_cfg_idx'(i_cfg_idx))
                    apu_pkg::CFG_IMAGE_WIDTH:
                        r_img_w <= i_cfg_data[apu_pkg::IMG_W_W-1:0];
                    apu_pkg::CFG_IMAGE_HEIGHT:
                        r_img_h <= i_cfg_data[apu_pkg::IMG_H_W-1:0];
                    apu_pkg::CFG_BYTES_PER_PIXEL:
                        r_bpp   <= i_cfg_data[apu_pkg::BPP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (move) begin
                r_left <= pix;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pix_ch0      = r_out_pix[7:0];
    assign o_pix_ch1      = r_out_pix[15:8];
    assign o_pix_ch2      = r_out_pix[23:16];
    assign o_pix_ch3      = r_out_pix[31:24];
    assign o_end_of_image = r_out_eoi;

endmodule

// File: rtl/apu_predict.sv
`timescale 1ns / 1ps

module apu_predict (
    input  apu_pkg::t_pred_ctl             i_ctl,
    input  logic [apu_pkg::WORD_W-1:0]     i_diff,
    input  logic [apu_pkg::WORD_W-1:0]     i_left,
    input  logic [apu_pkg::WORD_W-1:0]     i_up,
    output logic [apu_pkg::WORD_W-1:0]     o_pix
);

    always_comb begin
        logic [apu_pkg::PIX_W-1:0] l;
        logic [apu_pkg::PIX_W-1:0] u;
        logic [apu_pkg::PIX_W-1:0] pred;
        logic [apu_pkg::PIX_W:0]   sum;
        o_pix = '0;
        for (int c = 0; c < apu_pkg::NUM_CH; c++) begin
            l    = i_left[c*apu_pkg::PIX_W +: apu_pkg::PIX_W];
            u    = i_up[c*apu_pkg::PIX_W +: apu_pkg::PIX_W];
            sum  = {1'b0, l} + {1'b0, u};
            priority if (i_ctl.has_left && i_ctl.has_up) begin
                pred = sum[apu_pkg::PIX_W:1];
            end else if (i_ctl.has_left) begin
                pred = l;
            end else if (i_ctl.has_up) begin
                pred = u;
            end else begin
                pred = '0;
            end
            if (i_ctl.ch_en[c]) begin
                o_pix[c*apu_pkg::PIX_W +: apu_pkg::PIX_W] =
                    i_diff[c*apu_pkg::PIX_W +: apu_pkg::PIX_W] + pred;
            end
        end
    end

endmodule

// File: rtl/apu_checker.sv
`timescale 1ns / 1ps

module apu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pix_ch0,
    input logic       o_end_of_image
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not empty after reset");

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while result path is free");

    a_result_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pix_ch0) && $stable(o_end_of_image))
        else $error("stalled result changed");

    a_no_result_without_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !$past(i_valid && o_ready) && $past(!o_valid || i_ready)
            && $past(o_ready) |-> ##1 !o_valid || $past(i_valid && o_ready))
        else $error("result appeared without a request");

endmodule

bind average_predictor_unfilter apu_checker u_apu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pix_ch0      (o_pix_ch0),
    .o_end_of_image (o_end_of_image)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int RAND_ITEMS  = 1530;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0] pix;
        logic        eoi;
    } t_pix_result;

    typedef struct packed {
        logic                           is_cfg;
        apu_pkg::t_cfg_idx              idx;
        logic [apu_pkg::CFG_DATA_W-1:0] data;
        logic [31:0]                    diffs;
        logic                           has_exp;
        logic [31:0]                    exp_pix;
        logic                           exp_eoi;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [apu_pkg::CFG_IDX_W-1:0]  i_cfg_idx = apu_pkg::CFG_NONE;
    logic [apu_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [7:0]                     i_diff_ch0 = '0;
    logic [7:0]                     i_diff_ch1 = '0;
    logic [7:0]                     i_diff_ch2 = '0;
    logic [7:0]                     i_diff_ch3 = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [7:0]                     o_pix_ch0;
    logic [7:0]                     o_pix_ch1;
    logic [7:0]                     o_pix_ch2;
    logic [7:0]                     o_pix_ch3;
    logic                           o_end_of_image;

    always #1 i_clk = ~i_clk;

    average_predictor_unfilter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_diff_ch0     (i_diff_ch0),
        .i_diff_ch1     (i_diff_ch1),
        .i_diff_ch2     (i_diff_ch2),
        .i_diff_ch3     (i_diff_ch3),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pix_ch0      (o_pix_ch0),
        .o_pix_ch1      (o_pix_ch1),
        .o_pix_ch2      (o_pix_ch2),
        .o_pix_ch3      (o_pix_ch3),
        .o_end_of_image (o_end_of_image)
    );

    // Mirror of the unfilter state and registers
    logic [31:0]                 line_mem [apu_pkg::MAX_WIDTH];
    logic [31:0]                 left_px;
    logic [apu_pkg::COL_W-1:0]   col_cnt;
    logic [apu_pkg::IMG_H_W-1:0] row_cnt;
    logic [apu_pkg::IMG_W_W-1:0] reg_width;
    logic [apu_pkg::IMG_H_W-1:0] reg_height;
    logic [apu_pkg::BPP_W-1:0]   reg_bpp;
    int                          filled_cols = 0;

    t_pix_result pending_pixels[$];
    t_stim_row   directed_rows[$];
    int          mismatches = 0;
    bit          no_idle = 1'b0;
    int          rx_wait = 0;
    bit          rx_took = 1'b0;

    function automatic int eff_width();
        if (reg_width == 0) return 1;
        if (reg_width > apu_pkg::MAX_WIDTH) return apu_pkg::MAX_WIDTH;
        return int'(reg_width);
    endfunction

    function automatic int eff_height();
        return (reg_height == 0) ? 1 : int'(reg_height);
    endfunction

    function automatic t_pix_result unfilter_pixel(input logic [31:0] diffs);
        int          w;
        int          h;
        int          nch;
        logic        has_left;
        logic        has_up;
        logic        last_col;
        logic        last_row;
        logic [31:0] up;
        logic [31:0] pix;
        logic [7:0]  l;
        logic [7:0]  u;
        logic [8:0]  sum;
        logic [7:0]  pred;
        t_pix_result r;
        w = eff_width();
        h = eff_height();
        nch = (reg_bpp == 0) ? 1 : ((reg_bpp > apu_pkg::MAX_CHANNELS) ?
              apu_pkg::MAX_CHANNELS : int'(reg_bpp));
        has_left = (col_cnt != 0);
        has_up = (row_cnt != 0);
        up = line_mem[col_cnt];
        pix = '0;
        for (int c = 0; c < nch; c++) begin
            l = left_px[8*c +: 8];
            u = up[8*c +: 8];
            sum = {1'b0, l} + {1'b0, u};
            if (has_left && has_up) pred = sum[8:1];
            else if (has_left) pred = l;
            else if (has_up) pred = u;
            else pred = '0;
            pix[8*c +: 8] = diffs[8*c +: 8] + pred;
        end
        line_mem[col_cnt] = pix;
        left_px = pix;
        if (int'(col_cnt) + 1 > filled_cols) filled_cols = int'(col_cnt) + 1;
        last_col = (int'(col_cnt) + 1 >= w);
        last_row = (int'(row_cnt) + 1 >= h);
        r.pix = pix;
        r.eoi = last_col && last_row;
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic int pixels_to_image_end();
        int w;
        int h;
        int cols_left;
        int rows_after;
        w = eff_width();
        h = eff_height();
        cols_left = (int'(col_cnt) + 1 >= w) ? 1 : w - int'(col_cnt);
        rows_after = (int'(row_cnt) + 1 >= h) ? 0 : h - 1 - int'(row_cnt);
        return cols_left + rows_after * w;
    endfunction

    // Keep every line store column that a later row reads already written
    function automatic bit width_allowed(input logic [apu_pkg::CFG_DATA_W-1:0] data);
        int w;
        w = int'(data[apu_pkg::IMG_W_W-1:0]);
        if (w == 0) w = 1;
        if (w > apu_pkg::MAX_WIDTH) w = apu_pkg::MAX_WIDTH;
        return (row_cnt == 0) || (w <= filled_cols);
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic [31:0] rand_diffs();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [apu_pkg::CFG_DATA_W-1:0] pick_width();
        int                          r;
        logic [apu_pkg::IMG_W_W-1:0] w;
        r = $urandom_range(0, 9);
        if (r < 6) w = apu_pkg::IMG_W_W'($urandom_range(1, 6));
        else if (r < 8) w = apu_pkg::IMG_W_W'($urandom_range(7, 40));
        else if (r == 8) begin
            case ($urandom_range(0, 2))
                0: w = 12'd0;
                1: w = 12'd2048;
                default: w = 12'hFFF;
            endcase
        end else w = apu_pkg::IMG_W_W'($urandom_range(0, 4095));
        return {4'($urandom), w};
    endfunction

    function automatic logic [apu_pkg::CFG_DATA_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(1, 5));
        if (r == 7) return '0;
        return 16'($urandom);
    endfunction

    function automatic void add_cfg(input apu_pkg::t_cfg_idx idx,
                                    input logic [apu_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pix(input logic [31:0] diffs, input logic has_exp,
                                    input logic [31:0] exp_pix, input logic exp_eoi);
        t_stim_row row;
        row = '0;
        row.idx = apu_pkg::CFG_NONE;
        row.diffs = diffs;
        row.has_exp = has_exp;
        row.exp_pix = exp_pix;
        row.exp_eoi = exp_eoi;
        directed_rows.push_back(row);
    endfunction

    task automatic write_reg(input apu_pkg::t_cfg_idx idx,
                             input logic [apu_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            apu_pkg::CFG_IMAGE_WIDTH:     reg_width = data[apu_pkg::IMG_W_W-1:0];
            apu_pkg::CFG_IMAGE_HEIGHT:    reg_height = data[apu_pkg::IMG_H_W-1:0];
            apu_pkg::CFG_BYTES_PER_PIXEL: reg_bpp = data[apu_pkg::BPP_W-1:0];
            default: ;
        endcase
    endtask

    // Hold the sender until every result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [31:0] diffs, input logic has_exp,
                              input logic [31:0] exp_pix, input logic exp_eoi);
        int          gap;
        t_pix_result r;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_diff_ch0 <= diffs[7:0];
        i_diff_ch1 <= diffs[15:8];
        i_diff_ch2 <= diffs[23:16];
        i_diff_ch3 <= diffs[31:24];
        do @(posedge i_clk); while (!o_ready);
        r = unfilter_pixel(diffs);
        if (has_exp) begin
            r.pix = exp_pix;
            r.eoi = exp_eoi;
        end
        pending_pixels.push_back(r);
    endtask

    task automatic note_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endtask

    always @(negedge i_clk) begin
        if (rx_took) begin
            rx_took = 1'b0;
            rx_wait = draw_wait();
        end
        if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pix_result want;
        logic [31:0] got;
        if (i_rst_n && o_valid && i_ready) begin
            rx_took = 1'b1;
            got = {o_pix_ch3, o_pix_ch2, o_pix_ch1, o_pix_ch0};
            if (pending_pixels.size() == 0) begin
                note_error("unexpected pixel", 32'h0, got);
            end else begin
                want = pending_pixels.pop_front();
                for (int c = 0; c < 4; c++)
                    if (got[8*c +: 8] !== want.pix[8*c +: 8])
                        note_error($sformatf("pix_ch%0d", c), 32'(want.pix[8*c +: 8]),
                                   32'(got[8*c +: 8]));
                if (o_end_of_image !== want.eoi)
                    note_error("end_of_image", 32'(want.eoi), 32'(o_end_of_image));
            end
        end
    end

    initial begin : stimulus
        int                             rem;
        int                             n;
        int                             sent;
        logic [apu_pkg::CFG_DATA_W-1:0] wdata;
        reg_width = 12'd1;
        reg_height = 16'd1;
        reg_bpp = 3'd4;
        left_px = '0;
        col_cnt = '0;
        row_cnt = '0;
        for (int i = 0; i < apu_pkg::MAX_WIDTH; i++) line_mem[i] = '0;

        add_pix(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1);
        add_pix(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        add_pix(32'h5AC3_A53C, 1'b1, 32'h5AC3_A53C, 1'b1);
        add_cfg(apu_pkg::CFG_BYTES_PER_PIXEL, 16'hFFF9);
        add_pix(32'h1234_5678, 1'b1, 32'h0000_0078, 1'b1);
        add_cfg(apu_pkg::CFG_BYTES_PER_PIXEL, 16'h0000);
        add_pix(32'hFFFF_FFFF, 1'b1, 32'h0000_00FF, 1'b1);
        add_cfg(apu_pkg::CFG_BYTES_PER_PIXEL, 16'h0007);
        add_pix(32'h0102_0304, 1'b1, 32'h0102_0304, 1'b1);
        add_cfg(apu_pkg::CFG_NONE, 16'hFFFF);
        add_pix(32'h55AA_55AA, 1'b1, 32'h55AA_55AA, 1'b1);
        add_cfg(apu_pkg::CFG_IMAGE_WIDTH, 16'h0000);
        add_cfg(apu_pkg::CFG_IMAGE_HEIGHT, 16'h0000);
        add_pix(32'h8080_8080, 1'b1, 32'h8080_8080, 1'b1);
        add_cfg(apu_pkg::CFG_IMAGE_WIDTH, 16'h0003);
        add_cfg(apu_pkg::CFG_IMAGE_HEIGHT, 16'h0002);
        add_cfg(apu_pkg::CFG_BYTES_PER_PIXEL, 16'h0003);
        add_pix(32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF, 1'b0);
        add_pix(32'h0000_0001, 1'b0, '0, 1'b0);
        add_pix(32'h8080_80FF, 1'b0, '0, 1'b0);
        add_pix(32'h00FF_7F01, 1'b0, '0, 1'b0);
        add_pix(32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_pix(32'h0102_0380, 1'b0, '0, 1'b0);
        add_cfg(apu_pkg::CFG_IMAGE_WIDTH, 16'hF002);
        add_cfg(apu_pkg::CFG_IMAGE_HEIGHT, 16'h0002);
        add_cfg(apu_pkg::CFG_BYTES_PER_PIXEL, 16'hFFFA);
        add_pix(32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_pix(32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_pix(32'h0101_0101, 1'b0, '0, 1'b0);
        add_pix(32'hFEFE_FEFE, 1'b0, '0, 1'b0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                drain_results();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                send_pixel(directed_rows[i].diffs, directed_rows[i].has_exp,
                           directed_rows[i].exp_pix, directed_rows[i].exp_eoi);
            end
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            no_idle = ($urandom_range(0, 5) == 0);
            drain_results();
            if ($urandom_range(0, 1) == 0) begin
                wdata = pick_width();
                if (width_allowed(wdata)) write_reg(apu_pkg::CFG_IMAGE_WIDTH, wdata);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(apu_pkg::CFG_IMAGE_HEIGHT, pick_height());
            if ($urandom_range(0, 2) == 0)
                write_reg(apu_pkg::CFG_BYTES_PER_PIXEL, 16'($urandom));
            if ($urandom_range(0, 9) == 0) write_reg(apu_pkg::CFG_NONE, 16'($urandom));
            rem = pixels_to_image_end();
            if (rem <= 200 && $urandom_range(0, 3) != 0) n = rem;
            else n = $urandom_range(1, 60);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 199) == 0) drain_results();
                send_pixel(rand_diffs(), 1'b0, '0, 1'b0);
            end
            sent += n;
        end
        no_idle = 1'b0;

        drain_results();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
